### sv/srrd_pkg.sv
// ----------------------------------------------------------------------------
// srrd_pkg
// Shared constants and types for the scan reply range decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package srrd_pkg;

  // Scan size limit; the value counter is sized so it can hold this count.
  localparam int MAX_ELEMENTS = 1024;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 6;
  localparam int PART_W  = 2 * DIGIT_W;
  localparam int VAL_W   = 3 * DIGIT_W;
  localparam int IDX_W   = 10;
  localparam int ELEM_W  = 11;
  localparam int HDR_W   = 3;
  localparam int CMP_W   = (CNT_W > ELEM_W) ? CNT_W : ELEM_W;

  localparam logic [BYTE_W-1:0] LINE_FEED  = 8'h0A;
  localparam logic [BYTE_W-1:0] DIGIT_BASE = 8'h30;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ELEM_W;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_LINES  = 2'd1;

  // Digit phases
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  typedef struct packed {
    logic take;   // push the held character as a digit
    logic clear;  // empty line: restart the reply
  } digit_ctl_t;

  typedef struct packed {
    logic [VAL_W-1:0] range_value;
    logic [IDX_W-1:0] value_index;
    logic             last_value;
  } range_result_t;

endpackage

`default_nettype wire

### sv/srrd_if.sv
// ----------------------------------------------------------------------------
// srrd_if
// Valid/ready channels of the scan reply range decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface srrd_byte_if;
  import srrd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface srrd_range_if;
  import srrd_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] range_value;
  logic [IDX_W-1:0] value_index;
  logic             last_value;
  modport source (output valid, output range_value, output value_index,
                  output last_value, input ready);
  modport sink   (input valid, input range_value, input value_index,
                  input last_value, output ready);
endinterface

interface srrd_cfg_if;
  import srrd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/scan_reply_range_decoder.sv
// ----------------------------------------------------------------------------
// scan_reply_range_decoder
// Byte-wise decoder of a range finder measurement reply into range values.
// ----------------------------------------------------------------------------
// Takes one reply byte per beat on in_ch and emits decoded 18-bit range values
// on out_ch, each with its index in the scan and a last flag on the value at
// the final index of the effective count. The first header_lines lines of a
// reply are skipped; in data lines the character before the line feed
// (checksum) is dropped unchecked, and characters are joined across lines in
// groups of three. An empty line ends the reply and restarts the parser. The
// parser and packer update in the cycle a beat is accepted; each character is
// held back until the next one arrives, so a value is packed into the output
// register when the beat after its third character is accepted. A byte can be
// accepted on every cycle unless stalled: in_ch stalls only while a result
// sits in the output register and out_ch is not ready. Values beyond the
// effective count (element_count capped at MAX_ELEMENTS) are decoded and
// dropped. cfg_ch is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_reply_range_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  srrd_byte_if.sink   in_ch,
  srrd_range_if.source out_ch,
  srrd_cfg_if.sink    cfg_ch
);
  import srrd_pkg::*;

  // Configuration registers
  logic [ELEM_W-1:0] element_count_r;
  logic [HDR_W-1:0]  header_lines_r;

  // Line parser state
  logic [HDR_W-1:0]  line_cnt_r,   line_cnt_nxt;
  logic              nonempty_r,   nonempty_nxt;
  logic [BYTE_W-1:0] held_byte_r,  held_byte_nxt;
  logic              held_valid_r, held_valid_nxt;

  // Output register
  logic          out_valid_r;
  range_result_t out_data_r;

  logic          accept;
  digit_ctl_t    ctl;
  logic          res_valid;
  range_result_t res;

  // Accept while the output register is empty or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Line parser: counts lines, skips header lines, holds one byte back so
  // the checksum before each line feed never reaches the packer.
  always_comb begin
    line_cnt_nxt   = line_cnt_r;
    nonempty_nxt   = nonempty_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    ctl            = '0;
    if (accept) begin
      if (in_ch.in_byte == LINE_FEED) begin
        if (!nonempty_r) begin
          // empty line: end of reply
          ctl.clear      = 1'b1;
          line_cnt_nxt   = '0;
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
        end else begin
          // drop the checksum held back
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
          nonempty_nxt   = 1'b0;
          if (line_cnt_r != '1) begin
            line_cnt_nxt = HDR_W'(line_cnt_r + HDR_W'(1));
          end
        end
      end else begin
        nonempty_nxt = 1'b1;
        if (line_cnt_r >= header_lines_r) begin
          ctl.take       = held_valid_r;
          held_byte_nxt  = in_ch.in_byte;
          held_valid_nxt = 1'b1;
        end
      end
    end
  end

  srrd_value_builder u_builder (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .ch            (held_byte_r),
    .element_count (element_count_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r <= ELEM_W'(769);
      header_lines_r  <= HDR_W'(3);
      line_cnt_r      <= '0;
      nonempty_r      <= 1'b0;
      held_byte_r     <= '0;
      held_valid_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_ELEMENT_COUNT: element_count_r <= cfg_ch.data;
          REG_HEADER_LINES:  header_lines_r  <= HDR_W'(cfg_ch.data);
          default: ;
        endcase
      end
      line_cnt_r   <= line_cnt_nxt;
      nonempty_r   <= nonempty_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.range_value = out_data_r.range_value;
  assign out_ch.value_index = out_data_r.value_index;
  assign out_ch.last_value  = out_data_r.last_value;

endmodule

`default_nettype wire

### sv/srrd_value_builder.sv
// ----------------------------------------------------------------------------
// srrd_value_builder
// Packs three six-bit characters into one range value and numbers it.
// ----------------------------------------------------------------------------
`default_nettype none

module srrd_value_builder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire srrd_pkg::digit_ctl_t        ctl,
  input  wire logic [srrd_pkg::BYTE_W-1:0] ch,
  input  wire logic [srrd_pkg::ELEM_W-1:0] element_count,
  output logic                             res_valid,
  output srrd_pkg::range_result_t          res
);
  import srrd_pkg::*;

  logic [1:0]         phase_r,   phase_nxt;
  logic [PART_W-1:0]  partial_r, partial_nxt;
  logic [CNT_W-1:0]   count_r,   count_nxt;

  logic [DIGIT_W-1:0] digit;
  logic [CMP_W-1:0]   limit;
  logic [CMP_W-1:0]   count_ext;

  // Digit wraps modulo 64 for characters outside the code range.
  assign digit = DIGIT_W'(ch - DIGIT_BASE);

  always_comb begin
    if (CMP_W'(element_count) > CMP_W'(MAX_ELEMENTS)) begin
      limit = CMP_W'(MAX_ELEMENTS);
    end else begin
      limit = CMP_W'(element_count);
    end
  end

  assign count_ext = CMP_W'(count_r);

  always_comb begin
    phase_nxt       = phase_r;
    partial_nxt     = partial_r;
    count_nxt       = count_r;
    res_valid       = 1'b0;
    res.range_value = {partial_r, digit};
    res.value_index = IDX_W'(count_r);
    res.last_value  = (CMP_W'(count_ext + CMP_W'(1)) == limit);
    if (ctl.clear) begin
      phase_nxt   = PHASE_FIRST;
      partial_nxt = '0;
      count_nxt   = '0;
    end else if (ctl.take) begin
      case (phase_r)
        PHASE_FIRST: begin
          partial_nxt = PART_W'(digit);
          phase_nxt   = PHASE_SECOND;
        end
        PHASE_SECOND: begin
          partial_nxt = {partial_r[DIGIT_W-1:0], digit};
          phase_nxt   = PHASE_THIRD;
        end
        PHASE_THIRD: begin
          partial_nxt = '0;
          phase_nxt   = PHASE_FIRST;
          if (count_ext < limit) begin
            res_valid = 1'b1;
            count_nxt = CNT_W'(count_r + CNT_W'(1));
          end
        end
        default: begin
          partial_nxt = '0;
          phase_nxt   = PHASE_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PHASE_FIRST;
      partial_r <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

`default_nettype wire
